// ===== hw/rtl/hmg_pkg.sv =====
package hmg_pkg;

  localparam int KIND_W  = 2;
  localparam int VALUE_W = 10;
  localparam int GAP_W   = 15;

  // Answer when fewer than two values are present.
  localparam logic [GAP_W-1:0] NO_GAP = GAP_W'(20000);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Control from the sequencer to the scan accumulator.
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

// ===== hw/rtl/hmg_ram.sv =====
module hmg_ram #(
  parameter int AW = 10,
  parameter int DW = 17
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hmg_scan.sv =====
module hmg_scan #(
  parameter int AW = 10,
  parameter int DW = 17
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hmg_pkg::scan_ctl_t        ctl_i,
  input  logic [AW-1:0]             index_i,
  input  logic [DW-1:0]             count_i,
  output logic [hmg_pkg::GAP_W-1:0] gap_o,
  output logic                      has_pair_o
);
  import hmg_pkg::*;

  localparam int CW = (AW > GAP_W) ? AW : GAP_W;

  logic [GAP_W-1:0] gap_q, gap_d;
  logic [AW-1:0]    last_q, last_d;
  logic             seen_q, seen_d;
  logic             pair_q, pair_d;
  logic             dup_q, dup_d;
  logic [AW-1:0]    diff;

  assign diff = index_i - last_q;

  always_comb begin
    gap_d  = gap_q;
    last_d = last_q;
    seen_d = seen_q;
    pair_d = pair_q;
    dup_d  = dup_q;
    if (ctl_i.clear) begin
      gap_d  = NO_GAP;
      seen_d = 1'b0;
      pair_d = 1'b0;
      dup_d  = 1'b0;
    end else if (ctl_i.sample && !dup_q && (count_i != '0)) begin
      if (count_i[DW-1:1] != '0) begin
        // A value present twice settles the answer for the rest of the scan.
        dup_d  = 1'b1;
        gap_d  = '0;
        pair_d = 1'b1;
      end else begin
        if (seen_q) begin
          pair_d = 1'b1;
          if (CW'(diff) < CW'(gap_q)) begin
            gap_d = GAP_W'(diff);
          end
        end
        last_d = index_i;
        seen_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q  <= NO_GAP;
      last_q <= '0;
      seen_q <= 1'b0;
      pair_q <= 1'b0;
      dup_q  <= 1'b0;
    end else begin
      gap_q  <= gap_d;
      last_q <= last_d;
      seen_q <= seen_d;
      pair_q <= pair_d;
      dup_q  <= dup_d;
    end
  end

  assign gap_o      = gap_q;
  assign has_pair_o = pair_q;

endmodule

// ===== hw/rtl/histogram_min_gap.sv =====
// Channel | Direction | Handshake           | Beat payload
// in      | input     | in_valid_i/ready_o  | kind_i, value_i
// out     | output    | out_valid_o/ready_i | gap_o, has_pair_o
//
// Add and remove read the count in ST_IDLE and write it back in ST_RMW.
// A query is bound by the single read port of the count
// memory, which the scan walks one entry per cycle.
// After reset a clearing pass zeroes the memory first.
// A result waits in the output register while adds and removes keep flowing.
// A scan that ends while that register is full holds until it is free.
module histogram_min_gap #(
  parameter int MAX_VALUE  = 1023,
  parameter int COUNT_BITS = 17
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [hmg_pkg::KIND_W-1:0]  kind_i,
  input  logic [hmg_pkg::VALUE_W-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hmg_pkg::GAP_W-1:0]   gap_o,
  output logic                        has_pair_o
);
  import hmg_pkg::*;

  localparam int AW = $clog2(MAX_VALUE + 1);
  localparam int DW = COUNT_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VALUE);

  state_e           state_q, state_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic             is_add_q, is_add_d;
  logic             out_valid_q, out_valid_d;
  logic [GAP_W-1:0] gap_q, gap_d;
  logic             pair_q, pair_d;

  logic             accept;
  logic             value_ok;
  logic [AW-1:0]    value_addr;
  logic [AW-1:0]    raddr;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [DW-1:0]    wdata;
  logic [DW-1:0]    rdata;
  scan_ctl_t        scan_ctl;
  logic [GAP_W-1:0] scan_gap;
  logic             scan_pair;

  assign accept     = in_valid_i && in_ready_o;
  assign value_addr = AW'(value_i);
  // Value zero is never counted, and values beyond the histogram are dropped.
  assign value_ok   = (value_i != '0) && (32'(value_i) <= 32'(MAX_VALUE));

  // Sequencer: the whole block works on one beat at a time.
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    is_add_d    = is_add_q;
    out_valid_d = out_valid_q && !out_ready_i;
    gap_d       = gap_q;
    pair_d      = pair_q;
    in_ready_o  = 1'b0;
    raddr       = value_addr;
    we          = 1'b0;
    waddr       = addr_q;
    wdata       = '0;
    scan_ctl    = '0;

    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        if (addr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          case (kind_i)
            KIND_ADD, KIND_REMOVE: begin
              if (value_ok) begin
                // The count read issued now returns in the next cycle.
                addr_d   = value_addr;
                is_add_d = (kind_i == KIND_ADD);
                state_d  = ST_RMW;
              end
            end
            KIND_QUERY: begin
              raddr          = AW'(1);
              addr_d         = AW'(1);
              scan_ctl.clear = 1'b1;
              state_d        = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_RMW: begin
        // The write lands before the next beat can issue its read, so no
        // forwarding is needed.
        we    = 1'b1;
        waddr = addr_q;
        if (is_add_q) begin
          wdata = (rdata == '1) ? rdata : rdata + DW'(1);
        end else begin
          wdata = (rdata == '0) ? rdata : rdata - DW'(1);
        end
        state_d = ST_IDLE;
      end

      ST_SCAN: begin
        // The data in hand belongs to addr_q; the next entry is read ahead.
        raddr           = addr_q + AW'(1);
        scan_ctl.sample = 1'b1;
        if (addr_q == LAST_ADDR) begin
          state_d = ST_DONE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          gap_d       = scan_gap;
          pair_d      = scan_pair;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      is_add_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      is_add_q    <= is_add_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gap_q  <= gap_d;
    pair_q <= pair_d;
  end

  hmg_ram #(
    .AW(AW),
    .DW(DW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  hmg_scan #(
    .AW(AW),
    .DW(DW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .index_i   (addr_q),
    .count_i   (rdata),
    .gap_o     (scan_gap),
    .has_pair_o(scan_pair)
  );

  assign out_valid_o = out_valid_q;
  assign gap_o       = gap_q;
  assign has_pair_o  = pair_q;

`ifndef SYNTHESIS
  // Entry zero is written only by the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && (state_q != ST_CLEAR)) |-> (waddr != '0))
    else $error("count of value zero modified");

  // A result appears only when a scan has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result without a finished scan");

  // A write-back always follows an accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW) |-> $past(in_valid_i && in_ready_o))
    else $error("write-back without an accepted beat");
`endif

endmodule

// ===== dv/testbench.sv =====
// Checks histogram_min_gap against a cycle-free model of the count store.
module testbench;
  import hmg_pkg::*;

  // Block configuration. The DUT runs with its default parameters, and the
  // model below mirrors them.
  localparam int MAX_VALUE  = 1023;
  localparam int COUNT_BITS = 17;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Kind 3 is not an operation. The block must swallow it without a result.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // A query walks the whole store, and the clearing pass after reset is just
  // as long. The limit covers both several times over, plus random stalls.
  localparam int QUIET_LIMIT = 20000;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
  } hist_op_t;

  typedef struct packed {
    logic [GAP_W-1:0] gap;
    logic             has_pair;
  } gap_answer_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  // Request side, driven by the testbench.
  logic               op_valid = 1'b0;
  logic               op_ready;
  logic [KIND_W-1:0]  op_kind  = '0;
  logic [VALUE_W-1:0] op_value = '0;

  // Answer side, driven by the block.
  logic               ans_valid;
  logic               ans_ready = 1'b0;
  logic [GAP_W-1:0]   ans_gap;
  logic               ans_has_pair;

  // Operations waiting to be driven, and query answers still to arrive.
  hist_op_t    pending_ops[$];
  gap_answer_t gap_answers[$];

  // Model of the count store, one saturating count per value.
  logic [COUNT_BITS-1:0] value_hist [0:MAX_VALUE];

  // Values that the random generator believes are present. It steers removes
  // toward them, so that the store stays sparse and gaps stay interesting.
  int live_vals[$];

  // Idle and stall rates in percent, changed between phases.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int err_count   = 0;
  int quiet_count = 0;

  histogram_min_gap DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (op_valid),
    .in_ready_o  (op_ready),
    .kind_i      (op_kind),
    .value_i     (op_value),
    .out_valid_o (ans_valid),
    .out_ready_i (ans_ready),
    .gap_o       (ans_gap),
    .has_pair_o  (ans_has_pair)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Answer to a query from the model: scan upward from 1. A count of two or
  // more ends the scan with gap zero. Otherwise neighbouring present values
  // narrow the gap, which starts at the no-pair answer.
  function automatic gap_answer_t scan_min_gap();
    gap_answer_t ans;
    int          last;
    bit          seen;
    ans.gap      = NO_GAP;
    ans.has_pair = 1'b0;
    last         = 0;
    seen         = 1'b0;
    for (int v = 1; v <= MAX_VALUE; v++) begin
      if (value_hist[v] == '0) continue;
      if (value_hist[v] >= 2) begin
        ans.gap      = '0;
        ans.has_pair = 1'b1;
        break;
      end
      if (seen) begin
        ans.has_pair = 1'b1;
        if (v - last < ans.gap) ans.gap = GAP_W'(v - last);
      end
      last = v;
      seen = 1'b1;
    end
    return ans;
  endfunction

  // Applies one accepted operation to the model. A query queues its answer.
  // Value zero and the unused kind leave the store alone. An add at the
  // ceiling and a remove at zero do nothing.
  task automatic apply_op(input hist_op_t op);
    if (op.kind == KIND_QUERY) begin
      gap_answers.push_back(scan_min_gap());
    end else if ((op.kind == KIND_ADD || op.kind == KIND_REMOVE) && op.value != '0) begin
      if (op.kind == KIND_ADD) begin
        if (value_hist[op.value] != COUNT_MAX) value_hist[op.value]++;
      end else if (value_hist[op.value] != '0) begin
        value_hist[op.value]--;
      end
    end
  endtask

  // Driver. A new beat is offered only when the previous one has gone. While
  // the block holds ready low, valid and the payload stay as they are.
  always @(posedge clk_i) begin : drive_ops
    hist_op_t nxt;
    if (!rst_n) begin
      op_valid <= 1'b0;
    end else if (!op_valid || op_ready) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_ops.pop_front();
        op_valid <= 1'b1;
        op_kind  <= nxt.kind;
        op_value <= nxt.value;
      end else begin
        op_valid <= 1'b0;
      end
    end
  end

  // Receiver. It stalls at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      ans_ready <= 1'b0;
    end else begin
      ans_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor. It sees the values from before the edge, so both sides are read
  // exactly as they stood when the handshake took place. Operations go into
  // the model, and answers are checked against the oldest expectation.
  always @(posedge clk_i) begin : watch_beats
    gap_answer_t want;
    if (rst_n) begin
      if (op_valid && op_ready) apply_op('{kind: op_kind, value: op_value});
      if (ans_valid && ans_ready) begin
        if (gap_answers.size() == 0) begin
          $error("answer with no query waiting: gap %0d has_pair %0b", ans_gap, ans_has_pair);
          err_count++;
        end else begin
          want = gap_answers.pop_front();
          if (ans_gap !== want.gap) begin
            $error("gap: expected %0d, actual %0d", want.gap, ans_gap);
            err_count++;
          end
          if (ans_has_pair !== want.has_pair) begin
            $error("has_pair: expected %0b, actual %0b", want.has_pair, ans_has_pair);
            err_count++;
          end
        end
      end
      // Watchdog: a long run of cycles without any beat means a hang.
      if ((op_valid && op_ready) || (ans_valid && ans_ready)) begin
        quiet_count = 0;
      end else begin
        quiet_count++;
      end
      if (quiet_count >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic push_op(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
    pending_ops.push_back('{kind: kind, value: value});
  endtask

  // Holds the sender back until every operation has gone and every answer
  // has come back, so that the block is fully idle.
  task automatic wait_drained();
    while (pending_ops.size() != 0 || op_valid || gap_answers.size() != 0)
      @(negedge clk_i);
  endtask

  // Random operations. Most are adds and removes that keep a handful of
  // values present, often close together or repeated, with queries mixed in.
  // About one in twelve is noise: the unused kind, value zero, or a remove
  // of a value that may be absent. Noise does not count toward n.
  task automatic fill_random(input int n);
    int               made;
    int               pick;
    int               idx;
    int               tmp;
    logic [VALUE_W-1:0] v;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        case ($urandom_range(2))
          0: push_op(KIND_UNUSED, VALUE_W'($urandom));
          1: push_op($urandom_range(1) ? KIND_ADD : KIND_REMOVE, '0);
          default: push_op(KIND_REMOVE, VALUE_W'($urandom_range(1, MAX_VALUE)));
        endcase
      end else if (pick < 27) begin
        // The value field of a query is ignored, so it carries random bits.
        push_op(KIND_QUERY, VALUE_W'($urandom));
        made++;
      end else if (live_vals.size() > 10 || (pick < 55 && live_vals.size() != 0)) begin
        idx = $urandom_range(live_vals.size() - 1);
        push_op(KIND_REMOVE, VALUE_W'(live_vals[idx]));
        live_vals.delete(idx);
        made++;
      end else begin
        pick = $urandom_range(99);
        if (pick < 15 && live_vals.size() != 0) begin
          v = VALUE_W'(live_vals[$urandom_range(live_vals.size() - 1)]);
        end else if (pick < 50 && live_vals.size() != 0) begin
          tmp = live_vals[$urandom_range(live_vals.size() - 1)] + $urandom_range(8) - 4;
          if (tmp < 1) tmp = 1;
          if (tmp > MAX_VALUE) tmp = MAX_VALUE;
          v = VALUE_W'(tmp);
        end else if (pick < 60) begin
          v = $urandom_range(1) ? VALUE_W'(1) : VALUE_W'(MAX_VALUE);
        end else begin
          v = VALUE_W'($urandom_range(1, MAX_VALUE));
        end
        push_op(KIND_ADD, v);
        live_vals.push_back(int'(v));
        made++;
      end
    end
  endtask

  initial begin
    foreach (value_hist[i]) value_hist[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed part, with no idling: empty store, value zero, a remove at
    // zero, a single value, the widest gap, a gap of one, a duplicate, the
    // unused kind, and back to empty.
    push_op(KIND_QUERY, '1);
    push_op(KIND_ADD, '0);
    push_op(KIND_REMOVE, VALUE_W'(5));
    push_op(KIND_QUERY, '0);
    push_op(KIND_ADD, VALUE_W'(MAX_VALUE));
    push_op(KIND_QUERY, '0);
    push_op(KIND_ADD, VALUE_W'(1));
    push_op(KIND_QUERY, '0);
    push_op(KIND_ADD, VALUE_W'(512));
    push_op(KIND_ADD, VALUE_W'(513));
    push_op(KIND_QUERY, '0);
    push_op(KIND_ADD, VALUE_W'(513));
    push_op(KIND_QUERY, '0);
    push_op(KIND_REMOVE, VALUE_W'(513));
    push_op(KIND_UNUSED, VALUE_W'(MAX_VALUE));
    push_op(KIND_REMOVE, '0);
    push_op(KIND_QUERY, '0);
    push_op(KIND_REMOVE, VALUE_W'(1));
    push_op(KIND_REMOVE, VALUE_W'(512));
    push_op(KIND_REMOVE, VALUE_W'(513));
    push_op(KIND_REMOVE, VALUE_W'(MAX_VALUE));
    push_op(KIND_QUERY, '0);
    wait_drained();

    // A count of three walked back down: the query at count one must see a
    // single value, and the last remove hits a count of zero.
    repeat (3) push_op(KIND_ADD, VALUE_W'(700));
    push_op(KIND_QUERY, '0);
    repeat (2) push_op(KIND_REMOVE, VALUE_W'(700));
    push_op(KIND_QUERY, '0);
    push_op(KIND_REMOVE, VALUE_W'(700));
    push_op(KIND_REMOVE, VALUE_W'(700));
    push_op(KIND_QUERY, '0);
    wait_drained();

    // Random phases: no idling, then an idle sender, then a stalling
    // receiver, then both. Each phase ends with the sender paused until all
    // answers are in.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 66;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 66;
        end
        default: begin
          send_idle_pct  = 26;
          recv_stall_pct = 26;
        end
      endcase
      fill_random(125);
      wait_drained();
    end

    // Let a full query's worth of cycles pass, so that a stray answer shows up.
    repeat (MAX_VALUE + 8) @(negedge clk_i);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
